[design/assert_macros.svh]
// Assertion macros shared by the checker files of this project.
// Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on a clock and disabled while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Shorthand for the usual clock and reset names.
`define ASSERT_STD(lbl, prop, msg) \
   `ASSERT_CLK_RST(lbl, clock, reset, prop, msg)

`endif

[design/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared widths, character codes, types and helpers of the integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int MAG_W   = 32;            // magnitude width, holds the most negative value
   localparam int DIGITS  = 10;            // decimal digits of a 32-bit magnitude
   localparam int BCD_W   = 4 * DIGITS;
   localparam int CNT_W   = $clog2(MAG_W);
   localparam int IDX_W   = $clog2(DIGITS);
   localparam int CHAR_W  = 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // Finished BCD word handed from the converter to the character stage.
   typedef struct packed {
      logic             valid;
      logic [BCD_W-1:0] bcd;
   } bcd_beat_type;

   // One result beat.
   typedef struct packed {
      logic              strobe;
      logic [CHAR_W-1:0] character;
      logic              is_last;
   } char_beat_type;

   // Double dabble correction of one BCD digit before it is shifted.
   function automatic logic [3:0] add3(input logic [3:0] digit);
      logic [3:0] res;
      if (digit >= 4'd5) begin
         res = digit + 4'd3;
      end else begin
         res = digit;
      end
      return res;
   endfunction

endpackage

[design/signed_int_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed 32-bit integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage: drive req_value and raise start while busy is low; that edge accepts
// the number and busy rises on the next cycle. The text comes back as a run of
// result beats on rsp_character, each marked by rsp_strobe for one cycle, most
// significant character first. A negative number begins with a minus sign,
// zero gives the single character '0', and the most negative value is
// handled through its full 32-bit magnitude. rsp_is_last marks the final beat.
// The first beat follows the accepting edge after the bit-serial double dabble
// converter has taken in all 32 magnitude bits, the BCD word has been handed
// over and the output register has been loaded. After that the character stage
// walks all ten BCD digits one per cycle, after a sign step for a negative
// number, so beats can have gaps where leading zeros are dropped. busy falls
// the cycle after the last beat, and no new number is accepted before then.
// Reset returns the block to idle and drops any text in flight. The receiver
// cannot stall the result beats, so every beat must be taken in the cycle it
// is shown.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
   import sitda_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [MAG_W-1:0]  req_value,
   output logic                     rsp_strobe,
   output logic [CHAR_W-1:0]        rsp_character,
   output logic                     rsp_is_last
);

   logic            busy_ff, busy_in;
   logic            neg_ff, neg_in;
   logic            accept;
   logic [MAG_W-1:0] mag;
   bcd_beat_type    dab_beat;
   char_beat_type   out_beat;

   assign accept = start && !busy_ff;

   // Two's complement negate; the most negative value maps onto 2^31, which
   // still fits the unsigned 32-bit magnitude.
   assign mag = req_value[MAG_W-1] ? (~req_value + 1'b1) : req_value;

   // The block stays busy from the accepting edge until the last beat has
   // been shown.
   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      if (accept) begin
         busy_in = 1'b1;
         neg_in  = req_value[MAG_W-1];
      end else if (out_beat.strobe && out_beat.is_last) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff <= neg_in;
   end

   sitda_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .mag    (mag),
      .result (dab_beat)
   );

   sitda_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .dab      (dab_beat),
      .negative (neg_ff),
      .beat     (out_beat)
   );

   assign busy          = busy_ff;
   assign rsp_strobe    = out_beat.strobe;
   assign rsp_character = out_beat.character;
   assign rsp_is_last   = out_beat.is_last;

endmodule

[design/sitda_dabble.sv]
// ----------------------------------------------------------------------------
// sitda_dabble
// Bit-serial binary to BCD converter: one magnitude bit enters per cycle.
// ----------------------------------------------------------------------------
module sitda_dabble
   import sitda_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic [MAG_W-1:0]   mag,
   output bcd_beat_type       result
);

   logic               running_ff, running_in;
   logic               valid_ff, valid_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   adj;

   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         adj[4*d +: 4] = add3(bcd_ff[4*d +: 4]);
      end
   end

   always_comb begin
      running_in = running_ff;
      valid_in   = 1'b0;
      cnt_in     = cnt_ff;
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      if (load) begin
         running_in = 1'b1;
         cnt_in     = CNT_W'(MAG_W - 1);
         mag_in     = mag;
         bcd_in     = '0;
      end else if (running_ff) begin
         bcd_in = {adj[BCD_W-2:0], mag_ff[MAG_W-1]};
         mag_in = {mag_ff[MAG_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            running_in = 1'b0;
            valid_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         running_ff <= running_in;
         valid_ff   <= valid_in;
      end
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign result.valid = valid_ff;
   assign result.bcd   = bcd_ff;

endmodule

[design/sitda_emit.sv]
// ----------------------------------------------------------------------------
// sitda_emit
// Character stage: sign for a negative number, then the BCD word one digit per
// cycle with leading zeros dropped.
// ----------------------------------------------------------------------------
module sitda_emit
   import sitda_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  bcd_beat_type  dab,
   input  logic          negative,
   output char_beat_type beat
);

   typedef enum logic [1:0] {ST_IDLE, ST_SIGN, ST_DIGIT} state_type;

   state_type          state_ff, state_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               lead_ff, lead_in;
   logic               strobe_ff, strobe_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [3:0]         top;

   assign top = bcd_ff[BCD_W-1 -: 4];

   always_comb begin
      state_in  = state_ff;
      bcd_in    = bcd_ff;
      idx_in    = idx_ff;
      lead_in   = lead_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (dab.valid) begin
               bcd_in   = dab.bcd;
               idx_in   = IDX_W'(DIGITS - 1);
               lead_in  = 1'b1;
               state_in = negative ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            strobe_in = 1'b1;
            char_in   = CHAR_MINUS;
            last_in   = 1'b0;
            state_in  = ST_DIGIT;
         end
         ST_DIGIT: begin
            // The units digit always goes out, so zero still yields one character.
            if (!lead_ff || top != 4'd0 || idx_ff == '0) begin
               strobe_in = 1'b1;
               char_in   = CHAR_ZERO | {4'd0, top};
               last_in   = (idx_ff == '0);
               lead_in   = 1'b0;
            end
            bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
            idx_in = idx_ff - 1'b1;
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      bcd_ff  <= bcd_in;
      idx_ff  <= idx_in;
      lead_ff <= lead_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign beat.strobe    = strobe_ff;
   assign beat.character = char_ff;
   assign beat.is_last   = last_ff;

endmodule

[design/sitda_checker.sv]
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks of the converter, bound onto the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sitda_checker
   import sitda_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [CHAR_W-1:0] rsp_character,
   input logic              rsp_is_last
);

   `ASSERT_STD(a_beat_while_busy, rsp_strobe |-> busy, "result beat outside a busy period")
   `ASSERT_STD(a_idle_after_last, rsp_strobe && rsp_is_last |=> !busy, "still busy after last beat")
   `ASSERT_STD(a_accept_sets_busy, start && !busy |=> busy && !rsp_strobe, "accept did not start work")
   `ASSERT_STD(a_sign_not_last, rsp_strobe && rsp_character == CHAR_MINUS |-> !rsp_is_last, "text ends in a sign")
   `ASSERT_STD(a_char_code, rsp_strobe |-> rsp_character == CHAR_MINUS || (rsp_character >= CHAR_ZERO && rsp_character <= 8'h39), "bad character code")

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_character (rsp_character),
   .rsp_is_last   (rsp_is_last)
);
